/* sv/tte_pkg.sv */
// Shared types, sizes and codes for the text terminal character engine.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package tte_pkg;

  localparam int MAX_COLS   = 80;
  localparam int MAX_ROWS   = 25;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CELL_W     = 16;
  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int CELL_AW    = $clog2(CELL_COUNT);
  localparam int PROD_W     = ROW_W + COL_W;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] REG_COLS  = 2'd0;
  localparam logic [1:0] REG_ROWS  = 2'd1;
  localparam logic [1:0] REG_COLOR = 2'd2;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [7:0]        RESET_COLOR = 8'd79;
  localparam logic [COL_W-1:0]  RESET_COLS  = COL_W'(MAX_COLS);
  localparam logic [ROW_W-1:0]  RESET_ROWS  = ROW_W'(MAX_ROWS);
  localparam logic [CELL_W-1:0] RESET_CELL  = {RESET_COLOR, CH_SPACE};

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       char_code;
    logic [COL_W-1:0] read_col;
    logic [ROW_W-1:0] read_row;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } result_t;

  typedef struct packed {
    logic [COL_W-1:0] columns_in_use;
    logic [ROW_W-1:0] rows_in_use;
    logic [7:0]       text_color;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] waddr;
    logic [CELL_W-1:0]  wdata;
    logic               re;
    logic [CELL_AW-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCROLL,
    S_FILL
  } state_t;

endpackage

/* sv/tte_ram.sv */
// Screen cell memory: one write port, one registered read port.
// Depends on tte_pkg.
`timescale 1ns / 1ps

module tte_ram (
  input  logic                        clk,
  input  tte_pkg::ram_req_t           req,
  output logic [tte_pkg::CELL_W-1:0]  rdata
);

  logic [tte_pkg::CELL_W-1:0] mem [tte_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

/* sv/tte_cfg.sv */
// APB register file: column count, row count, text color.
// Depends on tte_pkg.
`timescale 1ns / 1ps

module tte_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tte_pkg::APB_AW-1:0]  paddr,
  input  logic [tte_pkg::APB_DW-1:0]  pwdata,
  output logic [tte_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output tte_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns_in_use <= tte_pkg::RESET_COLS;
      cfg.rows_in_use    <= tte_pkg::RESET_ROWS;
      cfg.text_color     <= tte_pkg::RESET_COLOR;
    end else if (wr_en) begin
      unique case (reg_idx)
        tte_pkg::REG_COLS:  cfg.columns_in_use <= pwdata[tte_pkg::COL_W-1:0];
        tte_pkg::REG_ROWS:  cfg.rows_in_use    <= pwdata[tte_pkg::ROW_W-1:0];
        tte_pkg::REG_COLOR: cfg.text_color     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tte_pkg::REG_COLS:  prdata = tte_pkg::APB_DW'(cfg.columns_in_use);
      tte_pkg::REG_ROWS:  prdata = tte_pkg::APB_DW'(cfg.rows_in_use);
      tte_pkg::REG_COLOR: prdata = tte_pkg::APB_DW'(cfg.text_color);
      default:            prdata = '0;
    endcase
  end

endmodule

/* sv/tte_seq.sv */
// Command sequencer: cursor, character handling, scroll copy, fill sweeps.
// Depends on tte_pkg; drives the request port of tte_ram.
`timescale 1ns / 1ps

module tte_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  tte_pkg::item_t              item,
  input  tte_pkg::cfg_t               cfg,
  output logic                        busy,
  output logic                        done,
  output tte_pkg::result_t            result,
  output tte_pkg::ram_req_t           ram_req,
  input  logic [tte_pkg::CELL_W-1:0]  ram_rdata
);

  localparam int CW = tte_pkg::COL_W;
  localparam int RW = tte_pkg::ROW_W;
  localparam int AW = tte_pkg::CELL_AW;
  localparam int PW = tte_pkg::PROD_W;
  localparam logic [AW-1:0] CELL_LAST = AW'(tte_pkg::CELL_COUNT - 1);

  tte_pkg::state_t state, state_next;

  // control
  logic [AW-1:0] faddr, faddr_next;
  logic [RW-1:0] row, row_next;
  logic [CW-1:0] col, col_next;
  logic          pend, pend_next;
  logic          finish;

  // latched item and sizes
  logic [1:0]    cmd_q, cmd_q_next;
  logic [7:0]    ch_q, ch_q_next;
  logic [CW-1:0] rc_q, rc_q_next;
  logic [RW-1:0] rr_q, rr_q_next;
  logic [CW-1:0] cols_q, cols_q_next;
  logic [RW-1:0] rows_q, rows_q_next;
  logic [AW-1:0] total_q, total_q_next;
  logic [AW-1:0] src, src_next;
  logic [AW-1:0] pdst, pdst_next;
  logic [AW-1:0] fend, fend_next;
  logic [tte_pkg::CELL_W-1:0] res_data;

  // size clamp, used at accept
  logic [CW-1:0] cols_eff;
  logic [RW-1:0] rows_eff;
  logic [PW-1:0] total_eff;

  // put decode, from registered state only
  logic          nl, scroll, put_we, read_ok;
  logic [RW-1:0] row_new, mrow;
  logic [CW-1:0] col_new, mcol;
  logic [RW:0]   row_p1;
  logic [CW:0]   col_p1, tab_col;
  logic [tte_pkg::CELL_W-1:0] put_data, blank;
  logic [PW-1:0] lin_wide;
  logic [AW-1:0] lin;

  assign busy  = (state != tte_pkg::S_IDLE);
  assign blank = {cfg.text_color, tte_pkg::CH_SPACE};

  always_comb begin
    if (cfg.columns_in_use == '0) begin
      cols_eff = CW'(1);
    end else if (cfg.columns_in_use > CW'(tte_pkg::MAX_COLS)) begin
      cols_eff = CW'(tte_pkg::MAX_COLS);
    end else begin
      cols_eff = cfg.columns_in_use;
    end
    if (cfg.rows_in_use == '0) begin
      rows_eff = RW'(1);
    end else if (cfg.rows_in_use > RW'(tte_pkg::MAX_ROWS)) begin
      rows_eff = RW'(tte_pkg::MAX_ROWS);
    end else begin
      rows_eff = cfg.rows_in_use;
    end
  end

  assign total_eff = PW'(rows_eff) * PW'(cols_eff);

  always_comb begin
    nl       = 1'b0;
    scroll   = 1'b0;
    put_we   = 1'b0;
    put_data = blank;
    row_new  = row;
    col_new  = col;
    mrow     = row;
    mcol     = col;
    row_p1   = {1'b0, row} + (RW+1)'(1);
    col_p1   = {1'b0, col} + (CW+1)'(1);
    tab_col  = ({1'b0, col} + (CW+1)'(4)) & ~(CW+1)'(3);
    read_ok  = (rr_q < rows_q) && (rc_q < cols_q);
    if (cmd_q == tte_pkg::CMD_READ) begin
      mrow = rr_q;
      mcol = rc_q;
    end else if (cmd_q == tte_pkg::CMD_PUT) begin
      case (ch_q)
        tte_pkg::CH_NEWLINE: nl = 1'b1;
        tte_pkg::CH_RETURN:  col_new = '0;
        tte_pkg::CH_TAB: begin
          if (tab_col >= {1'b0, cols_q}) begin
            nl = 1'b1;
          end else begin
            col_new = tab_col[CW-1:0];
          end
        end
        tte_pkg::CH_BACKSPACE: begin
          if (col != '0) begin
            col_new = col - CW'(1);
            mcol    = col - CW'(1);
            put_we  = 1'b1;
          end else if (row != '0) begin
            row_new = row - RW'(1);
            col_new = cols_q - CW'(1);
            mrow    = row - RW'(1);
            mcol    = cols_q - CW'(1);
            put_we  = 1'b1;
          end
        end
        default: begin
          put_we   = 1'b1;
          put_data = {cfg.text_color, ch_q};
          if (col_p1 >= {1'b0, cols_q}) begin
            nl = 1'b1;
          end else begin
            col_new = col_p1[CW-1:0];
          end
        end
      endcase
      if (nl) begin
        col_new = '0;
        if (row_p1 < {1'b0, rows_q}) begin
          row_new = row_p1[RW-1:0];
        end else begin
          scroll = 1'b1;
        end
      end
    end
  end

  assign lin_wide = PW'(mrow) * PW'(cols_q) + PW'(mcol);
  assign lin      = lin_wide[AW-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tte_pkg::S_INIT: if (faddr == CELL_LAST) state_next = tte_pkg::S_IDLE;
      tte_pkg::S_IDLE: if (start) state_next = tte_pkg::S_EXEC;
      tte_pkg::S_EXEC: begin
        case (cmd_q)
          tte_pkg::CMD_PUT:   state_next = scroll ? tte_pkg::S_SCROLL : tte_pkg::S_IDLE;
          tte_pkg::CMD_READ:  state_next = read_ok ? tte_pkg::S_READ : tte_pkg::S_IDLE;
          tte_pkg::CMD_CLEAR: state_next = tte_pkg::S_FILL;
          default:            state_next = tte_pkg::S_IDLE;
        endcase
      end
      tte_pkg::S_READ:   state_next = tte_pkg::S_IDLE;
      tte_pkg::S_SCROLL: if (src >= total_q) state_next = tte_pkg::S_FILL;
      tte_pkg::S_FILL:   if (faddr == fend - AW'(1)) state_next = tte_pkg::S_IDLE;
      default:           state_next = tte_pkg::S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    ram_req      = '0;
    finish       = 1'b0;
    res_data     = '0;
    row_next     = row;
    col_next     = col;
    faddr_next   = faddr;
    fend_next    = fend;
    src_next     = src;
    pdst_next    = pdst;
    pend_next    = pend;
    cmd_q_next   = cmd_q;
    ch_q_next    = ch_q;
    rc_q_next    = rc_q;
    rr_q_next    = rr_q;
    cols_q_next  = cols_q;
    rows_q_next  = rows_q;
    total_q_next = total_q;
    unique case (state)
      tte_pkg::S_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = faddr;
        ram_req.wdata = tte_pkg::RESET_CELL;
        faddr_next    = faddr + AW'(1);
      end
      tte_pkg::S_IDLE: begin
        if (start) begin
          cmd_q_next   = item.cmd;
          ch_q_next    = item.char_code;
          rc_q_next    = item.read_col;
          rr_q_next    = item.read_row;
          cols_q_next  = cols_eff;
          rows_q_next  = rows_eff;
          total_q_next = total_eff[AW-1:0];
          row_next     = (row >= rows_eff) ? rows_eff - RW'(1) : row;
          col_next     = (col >= cols_eff) ? cols_eff - CW'(1) : col;
        end
      end
      tte_pkg::S_EXEC: begin
        case (cmd_q)
          tte_pkg::CMD_PUT: begin
            ram_req.we    = put_we;
            ram_req.waddr = lin;
            ram_req.wdata = put_data;
            row_next      = row_new;
            col_next      = col_new;
            if (scroll) begin
              src_next  = AW'(cols_q);
              pend_next = 1'b0;
            end else begin
              finish = 1'b1;
            end
          end
          tte_pkg::CMD_READ: begin
            if (read_ok) begin
              ram_req.re    = 1'b1;
              ram_req.raddr = lin;
            end else begin
              finish = 1'b1;
            end
          end
          tte_pkg::CMD_CLEAR: begin
            row_next   = '0;
            col_next   = '0;
            faddr_next = '0;
            fend_next  = total_q;
          end
          default: finish = 1'b1;
        endcase
      end
      tte_pkg::S_READ: begin
        finish   = 1'b1;
        res_data = ram_rdata;
      end
      tte_pkg::S_SCROLL: begin
        // read one row down, write it back one row up in the following cycle
        if (pend) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pdst;
          ram_req.wdata = ram_rdata;
        end
        if (src < total_q) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = src;
          pdst_next     = src - AW'(cols_q);
          src_next      = src + AW'(1);
          pend_next     = 1'b1;
        end else begin
          pend_next  = 1'b0;
          faddr_next = total_q - AW'(cols_q);
          fend_next  = total_q;
        end
      end
      tte_pkg::S_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = faddr;
        ram_req.wdata = blank;
        faddr_next    = faddr + AW'(1);
        if (faddr == fend - AW'(1)) finish = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tte_pkg::S_INIT;
      faddr <= '0;
      row   <= '0;
      col   <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      faddr <= faddr_next;
      row   <= row_next;
      col   <= col_next;
      pend  <= pend_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q   <= cmd_q_next;
    ch_q    <= ch_q_next;
    rc_q    <= rc_q_next;
    rr_q    <= rr_q_next;
    cols_q  <= cols_q_next;
    rows_q  <= rows_q_next;
    total_q <= total_q_next;
    src     <= src_next;
    pdst    <= pdst_next;
    fend    <= fend_next;
    if (finish) begin
      result.cell_data  <= res_data;
      result.cursor_row <= row_next;
      result.cursor_col <= col_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not make the engine busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (ram_req.waddr <= CELL_LAST))
    else $error("memory write beyond screen");

  a_scroll_order: assert property (@(posedge clk) disable iff (rst)
    (state == tte_pkg::S_SCROLL && pend) |-> (pdst < src))
    else $error("scroll write overtakes read");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (row < RW'(tte_pkg::MAX_ROWS)) && (col < CW'(tte_pkg::MAX_COLS)))
    else $error("cursor outside maximum screen");
`endif

endmodule

/* sv/text_terminal_character_engine.sv */
// Top level of the text terminal character engine.
// Depends on tte_pkg, tte_cfg, tte_ram, tte_seq.
`timescale 1ns / 1ps

// Usage
// - Command channel: a beat (item) is taken at a rising edge with start high
//   and busy low. cmd selects put character, read cell or clear screen.
// - Result channel: done is high for exactly one cycle with result valid;
//   one result per command. The receiver cannot stall, so it must take it.
// - APB port: columns_in_use at 0x0, rows_in_use at 0x4, text_color at 0x8.
//   Write only while busy is low and no result is outstanding. A size change
//   does not clear the screen.
// Command steps after accept:
// - put without scroll, unused command, out-of-range read: finished in S_EXEC
// - in-range read: through the registered memory read, returned in S_READ
// - clear: one cell written per cycle
// - put that scrolls: the copy streams one cell per
//   cycle through the single read and single write port of the screen
//   memory, then the bottom row is blanked one cell per cycle.
// Reset: rst (synchronous) restores the registers and homes the cursor, then
// a pass fills every cell of the screen memory with blanks; busy stays high
// through it while APB writes are still taken.

module text_terminal_character_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  tte_pkg::item_t              item,
  output logic                        busy,
  output logic                        done,
  output tte_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tte_pkg::APB_AW-1:0]  paddr,
  input  logic [tte_pkg::APB_DW-1:0]  pwdata,
  output logic [tte_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  tte_pkg::cfg_t              cfg;
  tte_pkg::ram_req_t          ram_req;
  logic [tte_pkg::CELL_W-1:0] ram_rdata;

  // register file
  tte_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // screen memory, one cell per address, linear address row*cols + col
  tte_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // sequencer owns the cursor and all memory traffic
  tte_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .cfg       (cfg),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

endmodule
